// ===== hw/rtl/sbda_pkg.sv =====
// ---------------------------------------------------------------------------
// sbda_pkg: shared types and constants
// Widths, ASCII codes and the digit cell operation code used by the
// signed binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package sbda_pkg;

	localparam int VALUE_W   = 32;
	localparam int DIGIT_W   = 4;
	localparam int CHAR_W    = 6;
	localparam int BIT_CNT_W = 5;

	localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = 5'd31;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_CLEAR  = 2'd1,
		CELL_DABBLE = 2'd2,
		CELL_SHIFT  = 2'd3
	} cell_op_t;

endpackage

// ===== hw/rtl/signed_binary_to_decimal_ascii_unit.sv =====
// ---------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit: 32-bit signed integer to ASCII text
// Converts each input word to its decimal text, most significant character
// first, with a leading '-' for negative values and a last flag on the
// final character. A row of BCD digit cells runs a double-dabble pass.
//
//   channel | handshake          | payload              | per word
//   --------+--------------------+----------------------+-----------------
//   in      | in_valid/in_stall  | value (32b signed)   | one word
//   out     | out_valid/out_stall| char_code, last_char | 1..11 words
//
// One number is loaded, then runs a bit-serial double-dabble pass over
// all 32 magnitude bits through the digit cells, then a leading-zero
// skip of one zero cell at a time, then its characters go out one by one
// whenever the output register is free.
// Reset clears control state only; the digit cells need none.
// The output register holds a character while out_stall is high; in_stall
// stays high from acceptance until the last character is loaded.
// ---------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_unit #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [sbda_pkg::VALUE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sbda_pkg::CHAR_W-1:0]        char_code,
	output logic                               last_char
);

	localparam int REM_W = $clog2(MAX_DIGITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                             state_q;
	logic [sbda_pkg::VALUE_W-1:0]       mag_q;
	logic                               neg_q;
	logic                               ovf_q;
	logic [sbda_pkg::BIT_CNT_W-1:0]     bit_cnt_q;
	logic [REM_W-1:0]                   rem_q;
	logic                               out_valid_q;
	logic [sbda_pkg::CHAR_W-1:0]        char_q;
	logic                               last_q;

	sbda_pkg::cell_op_t                 cell_op;
	logic                               chain_bit [MAX_DIGITS+1];
	logic [sbda_pkg::DIGIT_W-1:0]       chain_dig [MAX_DIGITS+1];
	logic [sbda_pkg::DIGIT_W-1:0]       top_digit;
	logic [sbda_pkg::VALUE_W-1:0]       value_u;
	logic                               accept;
	logic                               slot_free;
	logic                               skip_zero;

	assign value_u   = $unsigned(value);
	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign slot_free = !out_valid_q || !out_stall;
	assign top_digit = chain_dig[MAX_DIGITS];
	assign skip_zero = !ovf_q && (rem_q > REM_W'(1)) && (top_digit == '0);

	assign chain_bit[0] = mag_q[sbda_pkg::VALUE_W-1];
	assign chain_dig[0] = '0;

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		sbda_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.bit_in    (chain_bit[i]),
			.digit_in  (chain_dig[i]),
			.carry_out (chain_bit[i+1]),
			.digit     (chain_dig[i+1])
		);
	end

	always_comb begin
		cell_op = sbda_pkg::CELL_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) cell_op = sbda_pkg::CELL_CLEAR;
			end
			ST_CONV: cell_op = sbda_pkg::CELL_DABBLE;
			ST_SKIP: begin
				if (skip_zero) cell_op = sbda_pkg::CELL_SHIFT;
			end
			ST_EMIT: begin
				if (slot_free && !neg_q) cell_op = sbda_pkg::CELL_SHIFT;
			end
			default: cell_op = sbda_pkg::CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			neg_q     <= 1'b0;
			ovf_q     <= 1'b0;
			bit_cnt_q <= '0;
			rem_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q     <= value_u[sbda_pkg::VALUE_W-1];
						ovf_q     <= 1'b0;
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					// any carry out of the top cell means more digits than cells
					ovf_q     <= ovf_q | chain_bit[MAX_DIGITS];
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == sbda_pkg::BIT_CNT_LAST) begin
						rem_q   <= REM_W'(MAX_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_zero) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							rem_q <= rem_q - 1'b1;
							if (rem_q == REM_W'(1)) state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// magnitude register shifts out MSB first into the bottom cell
	always_ff @(posedge clk) begin
		if (accept) begin
			if (value_u[sbda_pkg::VALUE_W-1]) begin
				mag_q <= sbda_pkg::VALUE_W'(0) - value_u;
			end else begin
				mag_q <= value_u;
			end
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[sbda_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && slot_free) begin
			if (neg_q) begin
				char_q <= sbda_pkg::ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= sbda_pkg::ASCII_ZERO + {2'b00, top_digit};
				last_q <= (rem_q == REM_W'(1));
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

// ===== hw/rtl/sbda_cell.sv =====
// ---------------------------------------------------------------------------
// sbda_cell: one decimal digit cell
// Holds one BCD digit. In dabble mode it adds three when the digit is five
// or more, shifts in a bit from the cell below and hands its top bit to the
// cell above. In shift mode it takes the digit of the cell below.
// ---------------------------------------------------------------------------
module sbda_cell (
	input  logic                          clk,
	input  sbda_pkg::cell_op_t            op,
	input  logic                          bit_in,
	input  logic [sbda_pkg::DIGIT_W-1:0]  digit_in,
	output logic                          carry_out,
	output logic [sbda_pkg::DIGIT_W-1:0]  digit
);

	logic [sbda_pkg::DIGIT_W-1:0] digit_q;
	logic [sbda_pkg::DIGIT_W-1:0] adj;

	always_comb begin
		if (digit_q >= sbda_pkg::DABBLE_MIN) begin
			adj = digit_q + sbda_pkg::DABBLE_ADD;
		end else begin
			adj = digit_q;
		end
	end

	assign carry_out = adj[sbda_pkg::DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		unique case (op)
			sbda_pkg::CELL_HOLD:   digit_q <= digit_q;
			sbda_pkg::CELL_CLEAR:  digit_q <= '0;
			sbda_pkg::CELL_DABBLE: digit_q <= {adj[sbda_pkg::DIGIT_W-2:0], bit_in};
			sbda_pkg::CELL_SHIFT:  digit_q <= digit_in;
			default:               digit_q <= digit_q;
		endcase
	end

endmodule

// ===== hw/rtl/sbda_checker.sv =====
// ---------------------------------------------------------------------------
// sbda_checker: port-level checks for the decimal ASCII converter
// Watches the handshakes and the character stream on the top-level ports.
// ---------------------------------------------------------------------------
module sbda_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sbda_pkg::CHAR_W-1:0]   char_code,
	input logic                          last_char
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("stalled output word changed");

	// only '-' or a digit leaves the block
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == sbda_pkg::ASCII_MINUS) ||
			((char_code >= sbda_pkg::ASCII_ZERO) && (char_code <= sbda_pkg::ASCII_NINE)))
		else $error("character code out of range");

	// a sign never ends a number
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == sbda_pkg::ASCII_MINUS) |-> !last_char)
		else $error("minus sign flagged as last character");

	// a taken word keeps the input stalled while it converts
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting a word");

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker u_sbda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.char_code (char_code),
	.last_char (last_char)
);

// ===== verif/sbda_checker.sv =====
// ---------------------------------------------------------------------------
// sbda_scoreboard: scoreboard for the decimal ASCII converter
// Watches both channels of the converter, works out the character stream
// of every accepted number, and compares each character that leaves the
// block, field by field, with the oldest one still due.
// ---------------------------------------------------------------------------
module sbda_scoreboard #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [sbda_pkg::VALUE_W-1:0] value,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [sbda_pkg::CHAR_W-1:0]         char_code,
	input  logic                                last_char,
	output int                                  errors,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [sbda_pkg::CHAR_W-1:0] code;
		logic                        last;
	} text_char_t;

	text_char_t due_chars[$];

	assign pending = due_chars.size();

	// Queue the text of one number: optional '-', then digits, most
	// significant first; keep only the low MAX_DIGITS digits.
	task automatic queue_decimal_text(input logic [sbda_pkg::VALUE_W-1:0] raw);
		logic                         neg;
		logic [sbda_pkg::VALUE_W-1:0] mag;
		logic [sbda_pkg::DIGIT_W-1:0] digits [MAX_DIGITS];
		int                           n;
		text_char_t                   c;
		neg = raw[sbda_pkg::VALUE_W-1];
		mag = neg ? (~raw + 1'b1) : raw;
		n = 0;
		do begin
			digits[n] = sbda_pkg::DIGIT_W'(mag % 10);
			n++;
			mag = mag / 10;
		end while (mag != 0 && n < MAX_DIGITS);
		if (neg) begin
			c.code = sbda_pkg::ASCII_MINUS;
			c.last = 1'b0;
			due_chars.push_back(c);
		end
		for (int i = n - 1; i >= 0; i--) begin
			c.code = sbda_pkg::ASCII_ZERO + sbda_pkg::CHAR_W'(digits[i]);
			c.last = (i == 0);
			due_chars.push_back(c);
		end
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				queue_decimal_text(value);
			if (out_valid && !out_stall) begin
				if (due_chars.size() == 0) begin
					$error("unexpected word: char_code %0d last_char %0b",
						char_code, last_char);
					errors++;
				end else begin
					want = due_chars.pop_front();
					if (char_code !== want.code) begin
						$error("char_code: expected %0d, actual %0d",
							want.code, char_code);
						errors++;
					end
					if (last_char !== want.last) begin
						$error("last_char: expected %0b, actual %0b",
							want.last, last_char);
						errors++;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb: testbench top for the decimal ASCII converter
// Feeds directed and random signed numbers in bursts with random gaps,
// stalls the character output on changing patterns, and leaves the checking
// to sbda_scoreboard and the bound sbda_checker; reports the verdict at the end.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 200;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic signed [sbda_pkg::VALUE_W-1:0] value;
	logic                                out_valid;
	logic                                out_stall;
	logic [sbda_pkg::CHAR_W-1:0]         char_code;
	logic                                last_char;
	int                                  errors;
	int                                  pending;
	int                                  cycles;

	signed_binary_to_decimal_ascii_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	sbda_scoreboard i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Receiver: switch between stall patterns every so often.
	initial begin
		stall_mode_t mode;
		int          hold;
		int          phase;
		out_stall = 1'b0;
		mode = STALL_NONE;
		hold = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
				hold = $urandom_range(20, 200);
			end
			hold--;
			phase++;
			case (mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: out_stall <= (phase % 5) < 2;
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	// Mix of full-width values, short numbers of every length and values
	// near powers of ten and the range ends.
	function automatic logic signed [sbda_pkg::VALUE_W-1:0] pick_value();
		logic [sbda_pkg::VALUE_W-1:0] mag;
		int unsigned                  top;
		case ($urandom_range(0, 3))
			0: mag = $urandom;
			1: begin
				top = 1;
				repeat ($urandom_range(1, 9)) top = top * 10;
				mag = $urandom_range(0, top - 1);
			end
			2: begin
				top = 1;
				repeat ($urandom_range(0, 9)) top = top * 10;
				mag = top + $urandom_range(0, 2) - 1;
			end
			default: mag = 32'h7FFF_FFFF - $urandom_range(0, 20);
		endcase
		if ($urandom_range(0, 1))
			mag = ~mag + 1'b1;
		return mag;
	endfunction

	task automatic send_word(input logic signed [sbda_pkg::VALUE_W-1:0] v);
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		logic signed [sbda_pkg::VALUE_W-1:0] numbers [$];
		int                                  idx;
		int                                  burst;
		int                                  gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		numbers = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, 32'sd100, 32'sd999999999, 32'sd1000000000,
			-32'sd1000000000, 32'sd1234567890, -32'sd1234567890,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
			32'hAAAA_AAAA, 32'sd4294967, -32'sd7
		};
		repeat (RANDOM_ITEMS) numbers.push_back(pick_value());
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idx = 0;
		while (idx < numbers.size()) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && idx < numbers.size()) begin
				send_word(numbers[idx]);
				idx++;
				burst--;
			end
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
